>>> rtl/core/sliding_median_filter_assert.svh
// Assertion macros for the sliding median filter core.
// Used by rtl/core modules; relies on clk and rst_n in the including scope.
`ifndef SLIDING_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SMF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding_median_filter: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding_median_filter: next-cycle check failed");

`endif

>>> rtl/core/smf_pkg.sv
// Shared constants and types for the sliding median filter.
// No dependencies; imported by smf_median and sliding_median_filter.
`default_nettype none

package smf_pkg;

    localparam int WINDOW = 5;
    localparam int MID    = WINDOW / 2;
    localparam int DATA_W = 32;
    localparam int RANK_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);

    typedef logic [DATA_W-1:0]              word_t;
    typedef logic [WINDOW-1:0][DATA_W-1:0]  window_t;
    typedef logic [RANK_W-1:0]              rank_t;
    typedef logic [FILL_W-1:0]              fill_t;

endpackage

`default_nettype wire

>>> rtl/core/smf_median.sv
// Rank-based median select over one full window of signed values.
// Depends on smf_pkg for window size and types.
`default_nettype none

module smf_median (
    input  wire smf_pkg::window_t values,
    output smf_pkg::word_t        median
);
    import smf_pkg::*;

    rank_t rank [WINDOW];

    // Stable rank: ties are broken by position, so ranks form a permutation.
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if (j != i)
                begin
                    if (($signed(values[j]) < $signed(values[i])) ||
                        ((j < i) && (values[j] == values[i])))
                    begin
                        rank[i] = rank[i] + rank_t'(1);
                    end
                end
            end
        end
    end

    // Exactly one entry carries the middle rank.
    always_comb
    begin
        median = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (rank[i] == rank_t'(MID))
            begin
                median = median | values[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sliding_median_filter.sv
// Sliding-window median filter, top level. Uses smf_pkg, smf_median and
// the assertion macros in sliding_median_filter_assert.svh.
//
// The block keeps the last WINDOW (5) samples in a delay line. Each accepted
// sample beat shifts in and the oldest drops out. The first WINDOW-1 beats
// only fill the line and give no result; from then on every input beat gives
// exactly one output beat: the median of the window values (signed Q16.16,
// ranked in signed order), the timestamp of the center position of the window
// in arrival order, and a count of results so far that saturates at all ones.
// Throughput is one sample per cycle unless the output stalls. Each input
// beat loads the delay line; the rank network (WINDOW*(WINDOW-1) comparators
// and a one-hot select) then feeds the output register once it is free.
// Input ready stays high unless both the pending window and the output
// register hold undelivered results.
`default_nettype none
`include "sliding_median_filter_assert.svh"

module sliding_median_filter (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  smf_pkg::word_t sample_time,
    input  wire  smf_pkg::word_t sample_value,
    output logic                 out_valid,
    input  wire                  out_ready,
    output smf_pkg::word_t       center_time,
    output smf_pkg::word_t       median_value,
    output smf_pkg::word_t       result_count
);
    import smf_pkg::*;

    // Delay lines, index 0 oldest; payload only, no reset.
    window_t value_win_reg;
    window_t time_win_reg;

    fill_t   fill_level_reg;
    fill_t   fill_level_next;
    word_t   count_reg;
    word_t   count_next;
    logic    pend_valid_reg;
    logic    pend_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;

    word_t   center_time_reg;
    word_t   median_value_reg;
    word_t   result_count_reg;

    word_t   median_comb;

    logic    in_fire;
    logic    produce;
    logic    advance;

    smf_median u_median (
        .values (value_win_reg),
        .median (median_comb)
    );

    // Move the pending window result into the output register when it is free.
    assign advance  = pend_valid_reg && (!out_valid_reg || out_ready);
    // Shifting a new sample would clobber a pending window, so hold it first.
    assign in_ready = !pend_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;
    // The beat that fills the last slot is the first one with a result.
    assign produce  = in_fire && (fill_level_reg >= fill_t'(WINDOW - 1));

    always_comb
    begin
        fill_level_next = fill_level_reg;
        if (in_fire && (fill_level_reg != fill_t'(WINDOW)))
        begin
            fill_level_next = fill_level_reg + fill_t'(1);
        end

        // Saturate the running result count.
        count_next = count_reg;
        if (produce && (count_reg != '1))
        begin
            count_next = count_reg + word_t'(1);
        end

        pend_valid_next = pend_valid_reg;
        if (produce)
        begin
            pend_valid_next = 1'b1;
        end
        else if (advance)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_level_reg <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_level_reg <= fill_level_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Delay line: advance on every accepted beat, newest at the top.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                value_win_reg[i] <= value_win_reg[i + 1];
                time_win_reg[i]  <= time_win_reg[i + 1];
            end
            value_win_reg[WINDOW - 1] <= sample_value;
            time_win_reg[WINDOW - 1]  <= sample_time;
        end
    end

    // Output register. count_reg still holds the pending beat's count here,
    // since a new result can only land at the same edge.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            center_time_reg  <= time_win_reg[MID];
            median_value_reg <= median_comb;
            result_count_reg <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign center_time  = center_time_reg;
    assign median_value = median_value_reg;
    assign result_count = result_count_reg;

    // A pending result needs a full delay line.
    `SMF_ASSERT_NOW(a_pend_full, pend_valid_reg, fill_level_reg == fill_t'(WINDOW))
    // Delivered results are counted from one.
    `SMF_ASSERT_NOW(a_count_nonzero, out_valid_reg, result_count_reg != '0)
    // Input stalls only when both result slots are occupied.
    `SMF_ASSERT_NOW(a_stall_cause, !in_ready, pend_valid_reg && out_valid_reg)
    // A producing beat leaves a pending result.
    `SMF_ASSERT_NEXT(a_produce_pend, produce, pend_valid_reg)

endmodule

`default_nettype wire
